[hw/rtl/cds_pkg.sv]
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, field widths and calendar helpers for the date setter.
// ----------------------------------------------------------------------------
package cds_pkg;

    localparam int ReqW    = 3;
    localparam int DayW    = 5;
    localparam int MonthW  = 4;
    localparam int YearW   = 12;
    localparam int CursorW = 2;
    localparam int StatusW = 2;
    localparam int CfgIdxW = 1;

    localparam logic [MonthW-1:0] MonthFirst = MonthW'(1);
    localparam logic [MonthW-1:0] MonthLast  = MonthW'(12);
    localparam logic [MonthW-1:0] MonthFeb   = MonthW'(2);
    localparam logic [MonthW-1:0] MonthApr   = MonthW'(4);
    localparam logic [MonthW-1:0] MonthJun   = MonthW'(6);
    localparam logic [MonthW-1:0] MonthSep   = MonthW'(9);
    localparam logic [MonthW-1:0] MonthNov   = MonthW'(11);

    localparam logic [DayW-1:0] DayFirst = DayW'(1);
    localparam logic [DayW-1:0] Days28   = DayW'(28);
    localparam logic [DayW-1:0] Days29   = DayW'(29);
    localparam logic [DayW-1:0] Days30   = DayW'(30);
    localparam logic [DayW-1:0] Days31   = DayW'(31);

    localparam logic [YearW-1:0] YearMinReset = YearW'(2025);
    localparam logic [YearW-1:0] YearMaxReset = YearW'(4095);

    // y is a multiple of 25 iff (y * inverse(25) mod 2^12) <= 4095 / 25
    localparam logic [YearW-1:0] Inv25      = YearW'(3113);
    localparam logic [YearW-1:0] Max25Quot  = YearW'(4095 / 25);

    typedef enum logic [ReqW-1:0] {
        REQ_START = 3'd0,
        REQ_LEFT  = 3'd1,
        REQ_RIGHT = 3'd2,
        REQ_UP    = 3'd3,
        REQ_DOWN  = 3'd4,
        REQ_SAVE  = 3'd5,
        REQ_EXIT  = 3'd6,
        REQ_OTHER = 3'd7
    } req_t;

    typedef enum logic [CursorW-1:0] {
        CUR_DAY   = 2'd0,
        CUR_MONTH = 2'd1,
        CUR_YEAR  = 2'd2
    } cursor_t;

    typedef enum logic [StatusW-1:0] {
        ST_EDIT      = 2'd0,
        ST_SAVED     = 2'd1,
        ST_CANCELLED = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    localparam logic [CfgIdxW-1:0] CFG_YEAR_MIN = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_YEAR_MAX = 1'b1;

    typedef struct packed {
        logic                active;
        cursor_t             cursor;
        logic [DayW-1:0]     day;
        logic [MonthW-1:0]   month;
        logic [YearW-1:0]    year;
    } cds_state_t;

    function automatic logic is_leap(input logic [YearW-1:0] y);
        logic [2*YearW-1:0] prod;
        logic               div4;
        logic               div16;
        logic               div25;
        prod  = y * Inv25;
        div4  = (y[1:0] == 2'b00);
        div16 = (y[3:0] == 4'b0000);
        div25 = (prod[YearW-1:0] <= Max25Quot);
        return (div4 && !div25) || (div16 && div25);
    endfunction

    function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] m,
                                                     input logic [YearW-1:0]  y);
        logic [DayW-1:0] len;
        len = Days31;
        if (m == MonthFeb)
        begin
            len = is_leap(y) ? Days29 : Days28;
        end
        else if (m == MonthApr || m == MonthJun || m == MonthSep || m == MonthNov)
        begin
            len = Days30;
        end
        return len;
    endfunction

endpackage

[hw/rtl/cds_step.sv]
// ----------------------------------------------------------------------------
// cds_step
// Next-state and status logic for one key or start beat.
// ----------------------------------------------------------------------------
module cds_step (
    input  cds_pkg::cds_state_t             cur,
    input  cds_pkg::req_t                   req,
    input  logic [cds_pkg::DayW-1:0]        start_day,
    input  logic [cds_pkg::MonthW-1:0]      start_month,
    input  logic [cds_pkg::YearW-1:0]       start_year,
    input  logic [cds_pkg::YearW-1:0]       year_min,
    input  logic [cds_pkg::YearW-1:0]       year_max,
    output cds_pkg::cds_state_t             nxt,
    output cds_pkg::status_t                status
);
    import cds_pkg::*;

    logic [MonthW-1:0] cand_month;
    logic [YearW-1:0]  cand_year;
    logic [DayW-1:0]   mlen;
    logic              edit_up;
    logic              edit_down;

    assign edit_up   = cur.active && (req == REQ_UP);
    assign edit_down = cur.active && (req == REQ_DOWN);

    always_comb
    begin
        cand_month = cur.month;
        cand_year  = cur.year;
        if (edit_up && cur.cursor == CUR_MONTH)
        begin
            cand_month = (cur.month >= MonthLast) ? MonthFirst : cur.month + MonthW'(1);
        end
        else if (edit_down && cur.cursor == CUR_MONTH)
        begin
            cand_month = (cur.month <= MonthFirst) ? MonthLast : cur.month - MonthW'(1);
        end
        if (edit_up && cur.cursor == CUR_YEAR)
        begin
            cand_year = (cur.year >= year_max) ? year_min : cur.year + YearW'(1);
        end
        else if (edit_down && cur.cursor == CUR_YEAR)
        begin
            cand_year = (cur.year <= year_min) ? year_max : cur.year - YearW'(1);
        end
    end

    assign mlen = month_length(cand_month, cand_year);

    always_comb
    begin
        nxt    = cur;
        status = ST_EDIT;
        if (req == REQ_START)
        begin
            nxt.active = 1'b1;
            nxt.cursor = CUR_DAY;
            nxt.day    = (start_day == '0) ? DayFirst : start_day;
            if (start_month < MonthFirst)
            begin
                nxt.month = MonthFirst;
            end
            else if (start_month > MonthLast)
            begin
                nxt.month = MonthLast;
            end
            else
            begin
                nxt.month = start_month;
            end
            nxt.year = (start_year < year_min) ? year_min : start_year;
        end
        else if (!cur.active)
        begin
            status = ST_IGNORED;
        end
        else
        begin
            case (req)
                REQ_LEFT:
                begin
                    if (cur.cursor != CUR_DAY)
                    begin
                        nxt.cursor = cursor_t'(CursorW'(cur.cursor) - CursorW'(1));
                    end
                end
                REQ_RIGHT:
                begin
                    if (cur.cursor != CUR_YEAR)
                    begin
                        nxt.cursor = cursor_t'(CursorW'(cur.cursor) + CursorW'(1));
                    end
                end
                REQ_UP, REQ_DOWN:
                begin
                    if (cur.cursor == CUR_DAY)
                    begin
                        if (req == REQ_UP)
                        begin
                            nxt.day = (cur.day >= mlen) ? DayFirst : cur.day + DayW'(1);
                        end
                        else
                        begin
                            nxt.day = (cur.day <= DayFirst) ? mlen : cur.day - DayW'(1);
                        end
                    end
                    else
                    begin
                        nxt.month = cand_month;
                        nxt.year  = cand_year;
                        nxt.day   = (cur.day > mlen) ? mlen : cur.day;
                    end
                end
                REQ_SAVE:
                begin
                    nxt.active = 1'b0;
                    status     = ST_SAVED;
                end
                REQ_EXIT:
                begin
                    nxt.active = 1'b0;
                    status     = ST_CANCELLED;
                end
                default:
                begin
                    status = ST_EDIT;
                end
            endcase
        end
    end

endmodule

[hw/rtl/calendar_date_setter_top.sv]
// ----------------------------------------------------------------------------
// calendar_date_setter_top
// Button-driven Gregorian date editor: start beat loads a date, key beats
// move the cursor, step day, month or year with wraparound, or save or cancel.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   in      | sink      | in_valid/in_stall  | req_type, start_day/month/year
//   out     | source    | out_valid/out_stall| day/month/year_out, cursor, status
//   cfg     | sink      | cfg_valid/ready    | cfg_index, cfg_data
//
// One result beat per input beat; out_valid rises once the accepted beat has
// passed from the input register into the result register.
// A new beat is taken every cycle while in_stall is low; the input register, the
// step logic and the result register form the only path, and the editor state
// updates with the result register. Reset clears the session and restores the
// year bounds. out_stall holds a valid result in the result register and, once
// the input register is full, raises in_stall in the same cycle.
// ----------------------------------------------------------------------------
module calendar_date_setter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [cds_pkg::ReqW-1:0]        req_type,
    input  logic [cds_pkg::DayW-1:0]        start_day,
    input  logic [cds_pkg::MonthW-1:0]      start_month,
    input  logic [cds_pkg::YearW-1:0]       start_year,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [cds_pkg::DayW-1:0]        day_out,
    output logic [cds_pkg::MonthW-1:0]      month_out,
    output logic [cds_pkg::YearW-1:0]       year_out,
    output logic [cds_pkg::CursorW-1:0]     cursor_out,
    output logic [cds_pkg::StatusW-1:0]     status,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cds_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [cds_pkg::YearW-1:0]       cfg_data
);
    import cds_pkg::*;

    logic              in_vld_reg;
    req_t              req_reg;
    logic [DayW-1:0]   sday_reg;
    logic [MonthW-1:0] smonth_reg;
    logic [YearW-1:0]  syear_reg;

    logic [YearW-1:0]  year_min_reg;
    logic [YearW-1:0]  year_max_reg;

    cds_state_t        state_reg;
    cds_state_t        state_next;
    status_t           status_next;

    logic              out_vld_reg;
    logic [DayW-1:0]   day_reg;
    logic [MonthW-1:0] month_reg;
    logic [YearW-1:0]  year_reg;
    cursor_t           cursor_reg;
    status_t           status_reg;

    logic              out_free;
    logic              fire;
    logic              in_take;

    assign out_free  = !out_vld_reg || !out_stall;
    assign fire      = in_vld_reg && out_free;
    assign in_stall  = in_vld_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_min_reg <= YearMinReset;
            year_max_reg <= YearMaxReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_YEAR_MIN: year_min_reg <= cfg_data;
                CFG_YEAR_MAX: year_max_reg <= cfg_data;
                default:      year_min_reg <= year_min_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            req_reg    <= req_t'(req_type);
            sday_reg   <= start_day;
            smonth_reg <= start_month;
            syear_reg  <= start_year;
        end
    end

    cds_step u_step (
        .cur         (state_reg),
        .req         (req_reg),
        .start_day   (sday_reg),
        .start_month (smonth_reg),
        .start_year  (syear_reg),
        .year_min    (year_min_reg),
        .year_max    (year_max_reg),
        .nxt         (state_next),
        .status      (status_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                state_reg <= state_next;
            end
            if (out_free)
            begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            day_reg    <= state_next.day;
            month_reg  <= state_next.month;
            year_reg   <= state_next.year;
            cursor_reg <= state_next.cursor;
            status_reg <= status_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign day_out    = day_reg;
    assign month_out  = month_reg;
    assign year_out   = year_reg;
    assign cursor_out = cursor_reg;
    assign status     = status_reg;

`ifndef NO_ASSERTIONS
    a_stall_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_vld_reg && out_vld_reg))
        else $error("input stall without a held beat");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cursor_out <= CUR_YEAR))
        else $error("cursor out of range");

    a_edit_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_EDIT) |->
            (month_out >= MonthFirst && month_out <= MonthLast && day_out >= DayFirst))
        else $error("editing result with invalid date");

    a_end_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_SAVED || status == ST_CANCELLED || status == ST_IGNORED))
            |-> !state_reg.active)
        else $error("session still open after end or ignored key");
`endif

endmodule
